@@ hdl/gis_pkg.sv @@
package gis_pkg;

  localparam int MAX_KEPT  = 16;
  localparam int TIME_W    = 16;
  localparam int CNT_OUT_W = 5;
  // count holds 0..MAX_KEPT, address covers 0..MAX_KEPT-1
  localparam int CNT_W     = $clog2(MAX_KEPT + 1);
  localparam int ADDR_W    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

  typedef struct packed {
    logic [TIME_W-1:0] interval_start;
    logic [TIME_W-1:0] interval_end;
    logic              first_of_set;
  } gis_in_t;

  typedef struct packed {
    logic                 accepted;
    logic [CNT_OUT_W-1:0] selected_count;
    logic                 store_full;
  } gis_out_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } gis_cmd_t;

  typedef struct packed {
    logic scan_done;
  } gis_sts_t;

endpackage

@@ hdl/gis_dp.sv @@
module gis_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  gis_pkg::gis_in_t  in_data,
  input  gis_pkg::gis_cmd_t cmd,
  output gis_pkg::gis_sts_t sts,
  output gis_pkg::gis_out_t out_data
);
  import gis_pkg::*;

  logic [TIME_W-1:0] kept_start_mem [MAX_KEPT];
  logic [TIME_W-1:0] kept_end_mem   [MAX_KEPT];

  gis_in_t           item_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              clash_r, clash_nxt;
  logic [TIME_W-1:0] rd_start_r, rd_end_r;
  gis_out_t          out_r;
  logic              hit;
  logic              room;
  logic [CNT_W-1:0]  count_inc;
  logic [CNT_OUT_W+CNT_W-1:0] count_ext;

  // conflict test against the stored entry read last cycle
  always_comb begin
    hit = ((item_r.interval_start > rd_start_r) && (item_r.interval_start < rd_end_r)) ||
          ((item_r.interval_end   > rd_start_r) && (item_r.interval_end   < rd_end_r)) ||
          ((item_r.interval_start <= rd_start_r) && (item_r.interval_end >= rd_end_r));
  end

  assign room      = (count_r < CNT_W'(MAX_KEPT));
  assign count_inc = count_r + CNT_W'(1);
  assign count_ext = {{CNT_OUT_W{1'b0}}, (room && !clash_r) ? count_inc : count_r};

  always_comb begin
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    rd_vld_nxt = rd_vld_r;
    clash_nxt  = clash_r;
    if (cmd.load) begin
      if (in_data.first_of_set) begin
        count_nxt = '0;
      end
      idx_nxt    = '0;
      rd_vld_nxt = 1'b0;
      clash_nxt  = 1'b0;
    end else if (cmd.scan) begin
      rd_vld_nxt = (idx_r != count_r);
      if (idx_r != count_r) begin
        idx_nxt = idx_r + CNT_W'(1);
      end
      if (rd_vld_r && hit) begin
        clash_nxt = 1'b1;
      end
    end
    if (cmd.commit && room && !clash_r) begin
      count_nxt = count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
      clash_r  <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
      rd_vld_r <= rd_vld_nxt;
      clash_r  <= clash_nxt;
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.commit) begin
      out_r.accepted       <= room && !clash_r;
      out_r.store_full     <= !room && !clash_r;
      out_r.selected_count <= count_ext[CNT_OUT_W-1:0];
    end
  end

  // store memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.commit && room && !clash_r) begin
      kept_start_mem[count_r[ADDR_W-1:0]] <= item_r.interval_start;
      kept_end_mem[count_r[ADDR_W-1:0]]   <= item_r.interval_end;
    end
    if (cmd.scan && (idx_r != count_r)) begin
      rd_start_r <= kept_start_mem[idx_r[ADDR_W-1:0]];
      rd_end_r   <= kept_end_mem[idx_r[ADDR_W-1:0]];
    end
  end

  assign sts.scan_done = (idx_r == count_r) && !rd_vld_r;
  assign out_data      = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_KEPT)) else $error("store count above capacity");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.load |-> idx_r <= count_r) else $error("scan index past store count");

  a_commit_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && room && !clash_r) |=> count_r == $past(count_inc))
    else $error("accepted interval did not grow the store");

endmodule

@@ hdl/gis_ctrl.sv @@
module gis_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  gis_pkg::gis_sts_t sts,
  output gis_pkg::gis_cmd_t cmd
);
  import gis_pkg::*;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load   = (state_r == ST_IDLE) && in_valid;
    cmd.scan   = (state_r == ST_SCAN);
    cmd.commit = (state_r == ST_SCAN) && sts.scan_done && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (out_valid_r && out_ready) begin
            out_valid_r <= 1'b0;
          end
          if (in_valid) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (sts.scan_done && slot_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end else if (out_valid_r && out_ready) begin
            out_valid_r <= 1'b0;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready)) else $error("result overwritten");

  a_commit_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.scan_done) else $error("commit before scan finished");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("second item taken while busy");

endmodule

@@ hdl/greedy_interval_selector.sv @@
// Greedy interval selector.
// Input channel (in_valid / in_ready / in_data) carries one interval per
// transaction: start, end and a first-of-set flag that empties the kept set
// before the interval is judged. Result channel (out_valid / out_ready /
// out_data) returns one transaction per interval: accepted, the running
// selected count and store_full (conflict-free but no room left).
// The store is read one entry per cycle through a single registered read
// port; the scan walks every kept entry, then the commit writes the result
// register, and the next interval is taken only after the commit.
// The result sits in an output register, so a new interval is taken while
// an earlier result still waits; if the receiver stalls, the following
// interval holds at its commit until the output register frees up.
// Reset clears the kept count and the handshake state; the stored intervals
// are not cleared and are only read below the kept count.
module greedy_interval_selector (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  gis_pkg::gis_in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output gis_pkg::gis_out_t out_data
);
  import gis_pkg::*;

  gis_cmd_t cmd;
  gis_sts_t sts;

  // sequence load, scan and commit
  gis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // hold the store, compare one entry per cycle, register the result
  gis_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

@@ bench/gis_checker.sv @@
`timescale 1ns / 100ps

module gis_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  gis_pkg::gis_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  gis_pkg::gis_out_t out_data,
  output int                fail_count,
  output int                verdicts_owed
);
  import gis_pkg::*;

  logic [TIME_W-1:0] kept_lo [MAX_KEPT];
  logic [TIME_W-1:0] kept_hi [MAX_KEPT];
  int                kept_num;
  int                fails;
  gis_out_t          verdict_q [$];

  // Judge one interval against the kept set and update the set.
  function automatic gis_out_t judge_interval(gis_in_t item);
    gis_out_t verdict;
    logic     clash;
    int       a, b, x, y;
    verdict = '0;
    clash   = 1'b0;
    a       = item.interval_start;
    b       = item.interval_end;
    if (item.first_of_set) kept_num = 0;
    for (int i = 0; i < kept_num; i++) begin
      x = kept_lo[i];
      y = kept_hi[i];
      if ((a > x && a < y) || (b > x && b < y) || (a <= x && b >= y)) clash = 1'b1;
    end
    if (!clash) begin
      if (kept_num < MAX_KEPT) begin
        kept_lo[kept_num] = item.interval_start;
        kept_hi[kept_num] = item.interval_end;
        kept_num++;
        verdict.accepted = 1'b1;
      end else begin
        verdict.store_full = 1'b1;
      end
    end
    verdict.selected_count = CNT_OUT_W'(kept_num);
    return verdict;
  endfunction

  initial begin
    kept_num = 0;
    fails    = 0;
  end

  always @(posedge clk) begin
    gis_out_t due;
    if (!rst_n) begin
      kept_num = 0;
      verdict_q.delete();
    end else begin
      // check results before queuing this edge's interval: they belong to older ones
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %p", $time, out_data);
          fails++;
        end else begin
          due = verdict_q.pop_front();
          if (out_data.accepted !== due.accepted) begin
            $display("%0t: accepted expected %0b got %0b", $time,
                     due.accepted, out_data.accepted);
            fails++;
          end
          if (out_data.selected_count !== due.selected_count) begin
            $display("%0t: selected_count expected %0d got %0d", $time,
                     due.selected_count, out_data.selected_count);
            fails++;
          end
          if (out_data.store_full !== due.store_full) begin
            $display("%0t: store_full expected %0b got %0b", $time,
                     due.store_full, out_data.store_full);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) verdict_q.insert(verdict_q.size(), judge_interval(in_data));
    end
    fail_count    <= fails;
    verdicts_owed <= verdict_q.size();
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import gis_pkg::*;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  gis_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  gis_out_t out_data;
  int       fail_count;
  int       verdicts_owed;

  // traffic shaping, per cycle chance in percent
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // long receiver hold-off: stimulus bumps the request, receiver serves it
  int hold_off_asked = 0;
  int hold_off_done  = 0;

  int sender_pct   [4] = '{0, 75, 0, 25};
  int receiver_pct [4] = '{0, 0, 75, 25};

  greedy_interval_selector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  gis_checker verdict_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .verdicts_owed (verdicts_owed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: stall at random, or hold off for a long stretch on request so
  // the block backs up and drops in_ready while the sender keeps offering.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_asked != hold_off_done) begin
        hold_left = 300;
        hold_off_done++;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one interval and hold it until the transaction completes, then
  // maybe idle. Call right after a rising edge.
  task automatic offer_interval(input logic [TIME_W-1:0] lo, input logic [TIME_W-1:0] hi,
                                input logic opens_set);
    in_valid <= 1'b1;
    in_data  <= '{interval_start: lo, interval_end: hi, first_of_set: opens_set};
    do @(posedge clk); while (!in_ready);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (verdicts_owed != 0);
  endtask

  // Mostly well-formed sets: open with first_of_set, then intervals packed in a
  // window whose size varies per set, so some sets fill the store and some are
  // dense with conflicts. Mix in reversed intervals, raw random values and a
  // stray first_of_set as noise.
  task automatic offer_random_sets(input int n_items);
    int sent, set_len, wbits, base, lo, hi, pick;
    sent = 0;
    while (sent < n_items) begin
      set_len = $urandom_range(1, 40);
      wbits   = $urandom_range(6, 16);
      base    = $urandom_range(0, 65535);
      for (int k = 0; k < set_len && sent < n_items; k++) begin
        pick = $urandom_range(99);
        lo   = base + $urandom_range(0, (1 << wbits) - 1);
        hi   = lo + $urandom_range(0, 1 << (wbits - 4));
        if (pick < 8) begin
          lo = $urandom();
          hi = $urandom();
        end else if (pick < 16) begin
          {lo, hi} = {hi, lo};
        end
        offer_interval(lo[TIME_W-1:0], hi[TIME_W-1:0], (k == 0) || (pick >= 97));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: open a set, then touching, start inside, end inside, cover,
    // identical, reversed and a conflict with the reversed one.
    offer_interval(16'd100, 16'd200, 1'b1);
    offer_interval(16'd200, 16'd300, 1'b0);
    offer_interval(16'd150, 16'd250, 1'b0);
    offer_interval(16'd50,  16'd150, 1'b0);
    offer_interval(16'd50,  16'd400, 1'b0);
    offer_interval(16'd100, 16'd200, 1'b0);
    offer_interval(16'd500, 16'd450, 1'b0);
    offer_interval(16'd460, 16'd470, 1'b0);
    // fill the store up to MAX_KEPT with disjoint intervals
    for (int k = 0; k < MAX_KEPT - 3; k++) begin
      offer_interval(TIME_W'(1000 + 10 * k), TIME_W'(1005 + 10 * k), 1'b0);
    end
    // full store: a clean interval is refused for room, a clashing one is not
    offer_interval(16'd60000, 16'd60010, 1'b0);
    offer_interval(16'd150,   16'd160,   1'b0);
    // extremes of the time range and degenerate intervals
    offer_interval(16'd0,     16'd65535, 1'b1);
    offer_interval(16'd0,     16'd0,     1'b0);
    offer_interval(16'd65535, 16'd65535, 1'b0);
    offer_interval(16'd0,     16'd0,     1'b0);
    offer_interval(16'd5,     16'd5,     1'b1);
    offer_interval(16'd5,     16'd5,     1'b0);
    wait_drained();

    // Random phases with different traffic shapes; drain between phases.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = sender_pct[p];
      recv_stall_pct = receiver_pct[p];
      if (p == 0) hold_off_asked++;
      offer_random_sets(450);
      wait_drained();
    end

    // let any late or spurious result show up
    repeat (40) @(posedge clk);
    if (fail_count == 0 && verdicts_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
